### hw/rtl/qsps_pkg.sv
`timescale 1ns / 1ps
// Package for the query string pair splitter: byte codes, field widths,
// queue depth and the item type passed from front to back. No dependencies.
package qsps_pkg;

	localparam logic [7:0] BYTE_EQ  = 8'h3D;	// '='
	localparam logic [7:0] BYTE_AMP = 8'h26;	// '&'

	localparam int FIELD_W = 12;
	localparam int CNT_W   = 11;
	localparam int FIELD_MAX = 4095;

	localparam logic [CNT_W-1:0] MAX_PAIRS_RESET = 11'd100;

	// Must be a power of two: pointers wrap by overflow.
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic is_eq;
		logic is_amp;
		logic fin;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_head_t;

endpackage

### hw/rtl/qsps_in_if.sv
`timescale 1ns / 1ps
// Input byte channel of the query string pair splitter.
// Depends on nothing.
interface qsps_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] query_byte;
	logic       final_byte;

	modport source (output valid, output query_byte, output final_byte, input ready);
	modport sink   (input valid, input query_byte, input final_byte, output ready);
endinterface

### hw/rtl/qsps_out_if.sv
`timescale 1ns / 1ps
// Result channel of the query string pair splitter.
// Depends on qsps_pkg for the field width.
interface qsps_out_if
	import qsps_pkg::*;
;
	logic               valid;
	logic               ready;
	logic               pair_valid;
	logic [FIELD_W-1:0] key_start;
	logic [FIELD_W-1:0] key_length;
	logic               has_value;
	logic [FIELD_W-1:0] value_start;
	logic [FIELD_W-1:0] value_length;
	logic               end_of_string;
	logic               limit_hit;

	modport source (
		output valid, output pair_valid, output key_start, output key_length,
		output has_value, output value_start, output value_length,
		output end_of_string, output limit_hit, input ready
	);
	modport sink (
		input valid, input pair_valid, input key_start, input key_length,
		input has_value, input value_start, input value_length,
		input end_of_string, input limit_hit, output ready
	);
endinterface

### hw/rtl/qsps_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel (max_pairs) of the query string pair splitter.
// Depends on qsps_pkg for the register width.
interface qsps_cfg_if
	import qsps_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/qsps_front.sv
`timescale 1ns / 1ps
// Front end: classifies each input byte and queues the class bits.
// Depends on qsps_pkg and qsps_in_if.
module qsps_front
	import qsps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	qsps_in_if.sink     query_in,
	output queue_head_t head,
	input  logic        pop
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

	item_t              entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_QW-1:0]  count_q;
	logic               push;
	logic               do_pop;
	item_t              in_item;

	assign query_in.ready = (count_q != CNT_QW'(QUEUE_DEPTH));
	assign push   = query_in.valid & query_in.ready;
	assign do_pop = pop & (count_q != '0);

	always_comb begin
		in_item.is_eq  = (query_in.query_byte == BYTE_EQ);
		in_item.is_amp = (query_in.query_byte == BYTE_AMP);
		in_item.fin    = query_in.final_byte;
	end

	assign head.valid = (count_q != '0);
	assign head.item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hw/rtl/qsps_back.sv
`timescale 1ns / 1ps
// Back end: pair tracking state, limit register and the result register.
// Depends on qsps_pkg, qsps_out_if and qsps_cfg_if.
module qsps_back
	import qsps_pkg::*;
#(
	parameter int MAX_LEN = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  queue_head_t head,
	output logic        pop,
	qsps_cfg_if.sink    cfg,
	qsps_out_if.source  pair_out
);

	localparam int PW = $clog2(MAX_LEN + 1);
	localparam logic [PW-1:0] MAX_POS = PW'(MAX_LEN);

	function automatic logic [PW-1:0] diff(input logic [PW-1:0] hi, input logic [PW-1:0] lo);
		diff = (hi > lo) ? (hi - lo) : '0;
	endfunction

	function automatic logic [FIELD_W-1:0] sat(input logic [PW-1:0] v);
		sat = (32'(v) > 32'(FIELD_MAX)) ? FIELD_W'(FIELD_MAX) : FIELD_W'(v);
	endfunction

	logic [CNT_W-1:0] max_pairs_q;
	logic [PW-1:0]    pos_q;
	logic [PW-1:0]    seg_q;
	logic             in_value_q;
	logic [PW-1:0]    pks_q;
	logic [PW-1:0]    pkl_q;
	logic [CNT_W-1:0] kept_cnt_q;
	logic             stopped_q;

	logic             out_valid_q;
	logic             pair_valid_q;
	logic [FIELD_W-1:0] key_start_q, key_length_q, value_start_q, value_length_q;
	logic             has_value_q, eos_q, limit_q;

	logic             advance;
	logic [PW-1:0]    nxt;
	logic             stop_eff, act, eq_case, amp_case;
	logic             iv_a;
	logic [PW-1:0]    pks_a, pkl_a, seg_a, close_end;
	logic             do_close, kept;
	logic [PW-1:0]    ks, kl, vs, vl;
	logic [CNT_W-1:0] kept_n;
	logic             stop_n, emit;

	assign cfg.ready = 1'b1;
	assign advance   = !out_valid_q || pair_out.ready;
	assign pop       = head.valid && advance;

	always_comb begin
		nxt      = (pos_q == MAX_POS) ? pos_q : pos_q + 1'b1;
		stop_eff = stopped_q || (kept_cnt_q >= max_pairs_q);
		act      = !stop_eff;
		eq_case  = act && head.item.is_eq && !in_value_q;
		amp_case = act && head.item.is_amp;
		// state after a key-ending '='
		iv_a     = eq_case || in_value_q;
		pks_a    = eq_case ? seg_q : pks_q;
		pkl_a    = eq_case ? diff(pos_q, seg_q) : pkl_q;
		seg_a    = eq_case ? nxt : seg_q;
		// '&' closes at its own offset, end of string one past the last byte
		close_end = amp_case ? pos_q : nxt;
		do_close  = amp_case || (act && head.item.fin && !head.item.is_amp &&
		            ((nxt != seg_a) || iv_a));
		ks = iv_a ? pks_a : seg_a;
		kl = iv_a ? pkl_a : diff(close_end, seg_a);
		vs = iv_a ? seg_a : '0;
		vl = iv_a ? diff(close_end, seg_a) : '0;
		kept   = do_close && (kl != '0);
		kept_n = kept_cnt_q + CNT_W'(kept);
		stop_n = stop_eff || (kept && (kept_n >= max_pairs_q));
		emit   = head.item.fin || kept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_pairs_q <= MAX_PAIRS_RESET;
			pos_q       <= '0;
			seg_q       <= '0;
			in_value_q  <= 1'b0;
			pks_q       <= '0;
			pkl_q       <= '0;
			kept_cnt_q  <= '0;
			stopped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				max_pairs_q <= cfg.data;
			end
			if (advance) begin
				out_valid_q <= pop && emit;
			end
			if (pop) begin
				if (head.item.fin) begin
					pos_q      <= '0;
					seg_q      <= '0;
					in_value_q <= 1'b0;
					pks_q      <= '0;
					pkl_q      <= '0;
					kept_cnt_q <= '0;
					stopped_q  <= 1'b0;
				end else begin
					pos_q      <= nxt;
					seg_q      <= amp_case ? nxt : seg_a;
					in_value_q <= amp_case ? 1'b0 : iv_a;
					pks_q      <= pks_a;
					pkl_q      <= pkl_a;
					kept_cnt_q <= kept_n;
					stopped_q  <= stop_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			pair_valid_q   <= kept;
			key_start_q    <= kept ? sat(ks) : '0;
			key_length_q   <= kept ? sat(kl) : '0;
			has_value_q    <= kept && iv_a;
			value_start_q  <= kept ? sat(vs) : '0;
			value_length_q <= kept ? sat(vl) : '0;
			eos_q          <= head.item.fin;
			limit_q        <= stop_n;
		end
	end

	assign pair_out.valid         = out_valid_q;
	assign pair_out.pair_valid    = pair_valid_q;
	assign pair_out.key_start     = key_start_q;
	assign pair_out.key_length    = key_length_q;
	assign pair_out.has_value     = has_value_q;
	assign pair_out.value_start   = value_start_q;
	assign pair_out.value_length  = value_length_q;
	assign pair_out.end_of_string = eos_q;
	assign pair_out.limit_hit     = limit_q;

endmodule

### hw/rtl/query_string_pair_splitter_core.sv
`timescale 1ns / 1ps
// Query string pair splitter, top level. Takes one byte per cycle unless pair_out stalls.
// A byte passes through the class queue, then the result register, to its result.
// Throughput: one byte per cycle while pair_out is not stalled, set by the back end.
// A two-entry class queue lets input continue while a result waits.
// Reset (arst_n low): queue empty, string state cleared, max_pairs = 100.
module query_string_pair_splitter_core
	import qsps_pkg::*;
#(
	parameter int MAX_LEN = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	qsps_in_if.sink     query_in,
	qsps_cfg_if.sink    cfg,
	qsps_out_if.source  pair_out
);

	queue_head_t head;
	logic        pop;

	qsps_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.query_in (query_in),
		.head     (head),
		.pop      (pop)
	);

	qsps_back #(
		.MAX_LEN (MAX_LEN)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.cfg      (cfg),
		.pair_out (pair_out)
	);

endmodule

### sim/qsps_pair_checker.sv
`timescale 1ns / 1ps
// Pair checker for the query string pair splitter: watches the byte, config and result
// channels, predicts each result and compares it. Depends on qsps_pkg and the qsps_*_if.
module qsps_pair_checker
	import qsps_pkg::*;
#(
	parameter int MAX_LEN = 4096
) (
	input  logic  clk,
	input  logic  arst_n,
	qsps_in_if    query_in,
	qsps_cfg_if   cfg,
	qsps_out_if   pair_out,
	output int    mismatches,
	output int    pending
);

	localparam int POS_W = $clog2(MAX_LEN + 1);

	typedef struct packed {
		logic               pair_valid;
		logic [FIELD_W-1:0] key_start;
		logic [FIELD_W-1:0] key_length;
		logic               has_value;
		logic [FIELD_W-1:0] value_start;
		logic [FIELD_W-1:0] value_length;
		logic               end_of_string;
		logic               limit_hit;
	} pair_result_t;

	pair_result_t expected_pairs[$];
	pair_result_t staged;
	pair_result_t seen;
	pair_result_t want;

	logic [CNT_W-1:0] max_pairs_r;
	logic [CNT_W-1:0] pairs_kept;
	logic [POS_W-1:0] byte_pos;
	logic [POS_W-1:0] seg_start;
	logic [POS_W-1:0] key_start_q;
	logic [POS_W-1:0] key_len_q;
	logic             in_value;
	logic             stopped;

	function automatic logic [FIELD_W-1:0] clip_field(input int unsigned v);
		return (v > FIELD_MAX) ? FIELD_W'(FIELD_MAX) : FIELD_W'(v);
	endfunction

	function automatic int unsigned span(input int unsigned hi, input int unsigned lo);
		return (hi > lo) ? hi - lo : 0;
	endfunction

	function automatic void clear_string();
		byte_pos    = '0;
		seg_start   = '0;
		in_value    = 1'b0;
		key_start_q = '0;
		key_len_q   = '0;
		pairs_kept  = '0;
		stopped     = 1'b0;
	endfunction

	// Close the open pair at offset stop; fills staged when the pair is kept.
	function automatic bit close_pair(input int unsigned stop);
		int unsigned ks, kl, vs, vl;
		vs = 0;
		vl = 0;
		if (in_value) begin
			ks = key_start_q;
			kl = key_len_q;
			vs = seg_start;
			vl = span(stop, seg_start);
		end else begin
			ks = seg_start;
			kl = span(stop, seg_start);
		end
		if (kl == 0 || pairs_kept >= max_pairs_r)
			return 1'b0;
		staged.pair_valid   = 1'b1;
		staged.key_start    = clip_field(ks);
		staged.key_length   = clip_field(kl);
		staged.has_value    = in_value;
		staged.value_start  = clip_field(vs);
		staged.value_length = clip_field(vl);
		pairs_kept = pairs_kept + 1'b1;
		if (pairs_kept >= max_pairs_r)
			stopped = 1'b1;
		return 1'b1;
	endfunction

	function automatic void split_byte(input logic [7:0] b, input logic fin);
		int unsigned cur, nxt;
		bit kept;
		cur = byte_pos;
		nxt = (cur + 1 > MAX_LEN) ? MAX_LEN : cur + 1;
		kept = 1'b0;
		staged = '0;
		if (pairs_kept >= max_pairs_r)
			stopped = 1'b1;
		if (!stopped) begin
			if (b == BYTE_EQ && !in_value) begin
				key_start_q = seg_start;
				key_len_q   = POS_W'(span(cur, seg_start));
				in_value    = 1'b1;
				seg_start   = POS_W'(nxt);
			end else if (b == BYTE_AMP) begin
				kept      = close_pair(cur);
				seg_start = POS_W'(nxt);
				in_value  = 1'b0;
			end
			// end of string closes a pair that is still open
			if (fin && b != BYTE_AMP && (nxt != seg_start || in_value))
				kept = close_pair(nxt);
		end
		byte_pos = POS_W'(nxt);
		if (fin) begin
			staged.end_of_string = 1'b1;
			staged.limit_hit     = stopped;
			expected_pairs.push_back(staged);
			clear_string();
		end else if (kept) begin
			staged.limit_hit = stopped;
			expected_pairs.push_back(staged);
		end
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned exp_val);
		$display("%0t ERROR %s: got %0d, want %0d", $time, what, got, exp_val);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_pairs_r = MAX_PAIRS_RESET;
			clear_string();
			expected_pairs.delete();
			mismatches = 0;
			pending    = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				max_pairs_r = cfg.data;
			if (pair_out.valid && pair_out.ready) begin
				seen = '{pair_out.pair_valid, pair_out.key_start, pair_out.key_length,
					pair_out.has_value, pair_out.value_start, pair_out.value_length,
					pair_out.end_of_string, pair_out.limit_hit};
				if (expected_pairs.size() == 0) begin
					report_mismatch("result with no request pending", 1, 0);
				end else begin
					want = expected_pairs.pop_front();
					if (seen.pair_valid != want.pair_valid)
						report_mismatch("pair_valid", seen.pair_valid, want.pair_valid);
					if (seen.key_start != want.key_start)
						report_mismatch("key_start", seen.key_start, want.key_start);
					if (seen.key_length != want.key_length)
						report_mismatch("key_length", seen.key_length, want.key_length);
					if (seen.has_value != want.has_value)
						report_mismatch("has_value", seen.has_value, want.has_value);
					if (seen.value_start != want.value_start)
						report_mismatch("value_start", seen.value_start, want.value_start);
					if (seen.value_length != want.value_length)
						report_mismatch("value_length", seen.value_length, want.value_length);
					if (seen.end_of_string != want.end_of_string)
						report_mismatch("end_of_string", seen.end_of_string,
							want.end_of_string);
					if (seen.limit_hit != want.limit_hit)
						report_mismatch("limit_hit", seen.limit_hit, want.limit_hit);
				end
			end
			if (query_in.valid && query_in.ready)
				split_byte(query_in.query_byte, query_in.final_byte);
			pending = expected_pairs.size();
		end
	end

endmodule

### sim/tb_query_string_pair_splitter_core.sv
`timescale 1ns / 1ps
// Testbench top for query_string_pair_splitter_core: clock, reset, byte and config
// stimulus, result back-pressure and verdict. Depends on qsps_pkg, the qsps_*_if and
// qsps_pair_checker.
module tb_query_string_pair_splitter_core;
	import qsps_pkg::*;

	localparam int MAX_LEN      = 4096;
	localparam int SETTLE       = 4;	// margin for in-flight bytes to settle
	localparam int PHASE_BYTES  = 170;
	localparam int LONG_RUN     = 40;	// longer key and value runs

	logic clk;
	logic arst_n;
	bit   no_idle;
	int   mismatches;
	int   pending;

	logic [7:0] query_buf[$];

	qsps_in_if  query_in();
	qsps_cfg_if cfg();
	qsps_out_if pair_out();

	query_string_pair_splitter_core #(.MAX_LEN(MAX_LEN)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.query_in (query_in),
		.cfg      (cfg),
		.pair_out (pair_out)
	);

	qsps_pair_checker #(.MAX_LEN(MAX_LEN)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.query_in   (query_in),
		.cfg        (cfg),
		.pair_out   (pair_out),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#2ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// valid stays high across back-to-back requests; lowered only for a gap or by drain
	task automatic push_byte(input logic [7:0] b, input logic fin);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			query_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		query_in.valid      <= 1'b1;
		query_in.query_byte <= b;
		query_in.final_byte <= fin;
		do @(posedge clk); while (!query_in.ready);
	endtask

	task automatic send_text(input string s, input bit terminated);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i], terminated && i == s.len() - 1);
	endtask

	task automatic send_buf(input bit terminated);
		for (int i = 0; i < query_buf.size(); i++)
			push_byte(query_buf[i], terminated && i == query_buf.size() - 1);
	endtask

	// wait until every predicted result is back, then let in-flight bytes settle
	task automatic drain();
		query_in.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_limit(input logic [CNT_W-1:0] v);
		drain();
		cfg.valid <= 1'b1;
		cfg.data  <= v;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (b == BYTE_EQ || b == BYTE_AMP);
		return b;
	endfunction

	// mostly well-formed key=value lists, with empty keys, repeated '=' and '&'
	// and a share of raw noise
	task automatic make_query();
		int npairs, klen, vlen;
		query_buf.delete();
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 12)) begin
				case ($urandom_range(0, 7))
					0: query_buf.push_back(BYTE_EQ);
					1: query_buf.push_back(BYTE_AMP);
					default: query_buf.push_back(8'($urandom_range(0, 255)));
				endcase
			end
		end else begin
			npairs = $urandom_range(1, 6);
			for (int p = 0; p < npairs; p++) begin
				if (p != 0) begin
					query_buf.push_back(BYTE_AMP);
					if ($urandom_range(0, 7) == 0)
						query_buf.push_back(BYTE_AMP);
				end
				klen = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
				repeat (klen) query_buf.push_back(plain_byte());
				if ($urandom_range(0, 3) != 0) begin
					query_buf.push_back(BYTE_EQ);
					vlen = $urandom_range(0, 4);
					repeat (vlen)
						query_buf.push_back(($urandom_range(0, 7) == 0) ? BYTE_EQ
							: plain_byte());
				end
			end
			if ($urandom_range(0, 5) == 0)
				query_buf.push_back(BYTE_AMP);
		end
	endtask

	initial begin
		int ready_gap;
		pair_out.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			ready_gap = no_idle ? 0 : $urandom_range(0, 9);
			if (ready_gap != 0) begin
				pair_out.ready <= 1'b0;
				repeat (ready_gap) @(posedge clk);
			end
			pair_out.ready <= 1'b1;
			do @(posedge clk); while (!(pair_out.valid && pair_out.ready));
		end
	end

	initial begin
		logic [CNT_W-1:0] limits[10];
		int sent;
		limits = '{11'd1, 11'd0, 11'd2047, 11'd3, 11'd1024, 11'd2, 11'd5, 11'd100,
			11'd1, 11'd2047};
		no_idle             = 1'b0;
		arst_n              = 1'b0;
		query_in.valid      = 1'b0;
		query_in.query_byte = '0;
		query_in.final_byte = 1'b0;
		cfg.valid           = 1'b0;
		cfg.data            = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: value, bare key, empty key, '=' inside a value
		send_text("a=1&b&=x&c==2", 1'b1);
		send_text("&", 1'b1);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b1);
		send_text("k=", 1'b1);
		// lowering the limit under the pairs already kept stops output at once
		send_text("a&b&c&", 1'b0);
		write_limit(11'd2);
		send_text("d", 1'b1);

		for (int ph = 0; ph < 10; ph++) begin
			write_limit((ph == 7) ? 11'($urandom_range(1, 20)) : limits[ph]);
			no_idle = ($urandom_range(0, 3) == 0);
			sent = 0;
			while (sent < PHASE_BYTES) begin
				make_query();
				send_buf($urandom_range(0, 9) != 0);
				sent += query_buf.size();
			end
		end

		// long key, then long value
		write_limit(11'd2047);
		no_idle = 1'b1;
		query_buf.delete();
		repeat (LONG_RUN) query_buf.push_back(plain_byte());
		query_buf.push_back(BYTE_EQ);
		query_buf.push_back(plain_byte());
		send_buf(1'b1);
		query_buf.delete();
		query_buf.push_back(plain_byte());
		query_buf.push_back(BYTE_EQ);
		repeat (LONG_RUN) query_buf.push_back(plain_byte());
		send_buf(1'b1);

		drain();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
